// ===== src/bhm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhm_pkg - shared types and constants for the battery hysteresis monitor
// Item, result and register types, code enums and the fan duty scaling.
// ----------------------------------------------------------------------------
package bhm_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_TRIP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_TRIP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_CLEAR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_CLEAR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd5;

	localparam logic [15:0] RST_LOW_TRIP      = 16'd7000;
	localparam logic [15:0] RST_CRIT_TRIP     = 16'd6600;
	localparam logic [15:0] RST_LOW_CLEAR     = 16'd7200;
	localparam logic [15:0] RST_CRIT_CLEAR    = 16'd6800;
	localparam logic [7:0]  RST_DEBOUNCE      = 8'd3;
	localparam logic [15:0] RST_POLL_INTERVAL = 16'd500;

	// indication periods in ms
	localparam logic [31:0] CRIT_FLASH_MS = 32'd160;
	localparam logic [31:0] CRIT_ALARM_MS = 32'd1000;
	localparam logic [31:0] LOW_FLASH_MS  = 32'd500;

	localparam logic [7:0] LED_CRIT_ENTER_R = 8'd40;
	localparam logic [7:0] LED_CRIT_FLASH_R = 8'd60;
	localparam logic [7:0] LED_LOW_R        = 8'd30;
	localparam logic [7:0] LED_LOW_G        = 8'd14;

	localparam logic [6:0]  PCT_MAX  = 7'd100;
	localparam logic [15:0] DUTY_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_SEED   = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_VACUUM = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		LVL_OK   = 2'd0,
		LVL_LOW  = 2'd1,
		LVL_CRIT = 2'd2
	} lvl_t;

	typedef enum logic [1:0] {
		TONE_NONE     = 2'd0,
		TONE_ALARM    = 2'd1,
		TONE_HEADS_UP = 2'd2
	} tone_t;

	typedef struct packed {
		cmd_t               command;
		logic [31:0]        now_ms;
		logic               reading_ok;
		logic [15:0]        pack_mv;
		logic signed [15:0] vacuum_pct;
	} item_t;

	typedef struct packed {
		lvl_t        pack_level;
		logic        cut_loads;
		logic        led_write;
		logic [7:0]  led_red;
		logic [7:0]  led_green;
		logic [7:0]  led_blue;
		tone_t       tone_kind;
		logic        fan_write;
		logic [15:0] fan_duty;
		logic        vacuum_refused;
		logic [6:0]  applied_pct;
	} result_t;

	typedef struct packed {
		logic [15:0] low_trip_mv;
		logic [15:0] crit_trip_mv;
		logic [15:0] low_clear_mv;
		logic [15:0] crit_clear_mv;
		logic [7:0]  debounce_polls;
		logic [15:0] poll_interval_ms;
	} cfg_t;

	// floor(p * 65535 / 100) for p in 0..100:
	// p*655 + floor(7p/20), the last term as (7p * 820) >> 14 (exact for 7p <= 700)
	function automatic logic [15:0] fan_duty_of(logic [6:0] p);
		logic [16:0] base;
		logic [9:0]  p7;
		logic [19:0] prod;
		base = 17'(p) * 17'd655;
		p7   = 10'(p) * 10'd7;
		prod = 20'(p7) * 20'd820;
		return 16'(base + 17'(prod[19:14]));
	endfunction

endpackage

// ===== src/bhm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhm_in_if - input item channel
// Valid/ready channel carrying one monitor item per transfer.
// ----------------------------------------------------------------------------
interface bhm_in_if;
	logic          valid;
	logic          ready;
	bhm_pkg::item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== src/bhm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhm_out_if - result channel
// Valid/ready channel carrying one monitor result per transfer.
// ----------------------------------------------------------------------------
interface bhm_out_if;
	logic             valid;
	logic             ready;
	bhm_pkg::result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== src/bhm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhm_cfg - configuration register file
// Write-only threshold, debounce and poll interval registers.
// ----------------------------------------------------------------------------
module bhm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [bhm_pkg::CFG_IDX_W-1:0]  index,
	input  logic [bhm_pkg::CFG_DATA_W-1:0] data,
	output bhm_pkg::cfg_t                  cfg
);

	bhm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_trip_mv      <= bhm_pkg::RST_LOW_TRIP;
			cfg_q.crit_trip_mv     <= bhm_pkg::RST_CRIT_TRIP;
			cfg_q.low_clear_mv     <= bhm_pkg::RST_LOW_CLEAR;
			cfg_q.crit_clear_mv    <= bhm_pkg::RST_CRIT_CLEAR;
			cfg_q.debounce_polls   <= bhm_pkg::RST_DEBOUNCE;
			cfg_q.poll_interval_ms <= bhm_pkg::RST_POLL_INTERVAL;
		end else if (we) begin
			case (index)
				bhm_pkg::REG_LOW_TRIP:      cfg_q.low_trip_mv      <= data;
				bhm_pkg::REG_CRIT_TRIP:     cfg_q.crit_trip_mv     <= data;
				bhm_pkg::REG_LOW_CLEAR:     cfg_q.low_clear_mv     <= data;
				bhm_pkg::REG_CRIT_CLEAR:    cfg_q.crit_clear_mv    <= data;
				bhm_pkg::REG_DEBOUNCE:      cfg_q.debounce_polls   <= data[7:0];
				bhm_pkg::REG_POLL_INTERVAL: cfg_q.poll_interval_ms <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/bhm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhm_core - level state, debounce and indication logic
// Holds the monitor state and forms one result per processed item.
// ----------------------------------------------------------------------------
module bhm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  bhm_pkg::item_t    item,
	input  bhm_pkg::cfg_t     cfg,
	output bhm_pkg::result_t  res
);

	bhm_pkg::lvl_t level_q, cand_q;
	logic [7:0]    cnt_q;
	logic [31:0]   poll_q, flash_q, alarm_q;
	logic          phase_q;

	bhm_pkg::lvl_t level_n, cand_n, want, seed_lvl, enter_lvl;
	logic [7:0]    cnt_n, cnt_inc;
	logic [31:0]   poll_n, flash_n, alarm_n;
	logic          phase_n, enter, tick, poll_due;
	logic [6:0]    pct;
	bhm_pkg::result_t r;

	// hysteresis: trips use trip thresholds, recoveries the clear thresholds
	always_comb begin
		case (level_q)
			bhm_pkg::LVL_OK:
				want = (item.pack_mv < cfg.low_trip_mv) ? bhm_pkg::LVL_LOW : bhm_pkg::LVL_OK;
			bhm_pkg::LVL_LOW: begin
				if (item.pack_mv < cfg.crit_trip_mv)
					want = bhm_pkg::LVL_CRIT;
				else if (item.pack_mv > cfg.low_clear_mv)
					want = bhm_pkg::LVL_OK;
				else
					want = bhm_pkg::LVL_LOW;
			end
			bhm_pkg::LVL_CRIT:
				want = (item.pack_mv > cfg.crit_clear_mv) ? bhm_pkg::LVL_LOW : bhm_pkg::LVL_CRIT;
			default: want = level_q;
		endcase
	end

	// seed classifies with no hysteresis
	assign seed_lvl = (item.pack_mv < cfg.crit_trip_mv) ? bhm_pkg::LVL_CRIT :
	                  (item.pack_mv < cfg.low_trip_mv)  ? bhm_pkg::LVL_LOW  : bhm_pkg::LVL_OK;

	assign cnt_inc  = cnt_q + 8'd1;
	assign poll_due = (item.now_ms - poll_q) >= {16'd0, cfg.poll_interval_ms};

	// clamp the signed request to 0..100
	always_comb begin
		if (item.vacuum_pct[15])
			pct = '0;
		else if (item.vacuum_pct[14:0] > 15'(bhm_pkg::PCT_MAX))
			pct = bhm_pkg::PCT_MAX;
		else
			pct = item.vacuum_pct[6:0];
	end

	always_comb begin
		level_n   = level_q;
		cand_n    = cand_q;
		cnt_n     = cnt_q;
		poll_n    = poll_q;
		flash_n   = flash_q;
		alarm_n   = alarm_q;
		phase_n   = phase_q;
		enter     = 1'b0;
		enter_lvl = bhm_pkg::LVL_OK;
		tick      = 1'b0;
		r         = '0;

		case (item.command)
			bhm_pkg::CMD_SEED: begin
				level_n = bhm_pkg::LVL_OK;
				cand_n  = bhm_pkg::LVL_OK;
				cnt_n   = '0;
				poll_n  = item.now_ms;
				flash_n = '0;
				alarm_n = '0;
				phase_n = 1'b0;
				if (item.reading_ok && seed_lvl != bhm_pkg::LVL_OK) begin
					enter     = 1'b1;
					enter_lvl = seed_lvl;
				end
			end
			bhm_pkg::CMD_TICK: begin
				tick = 1'b1;
				if (poll_due) begin
					poll_n = item.now_ms;
					if (item.reading_ok) begin
						if (want == level_q) begin
							cnt_n = '0;
						end else if (want == cand_q) begin
							// zero debounce acts as one
							if (cnt_inc >= cfg.debounce_polls) begin
								cnt_n     = '0;
								enter     = 1'b1;
								enter_lvl = want;
							end else begin
								cnt_n = cnt_inc;
							end
						end else begin
							cand_n = want;
							cnt_n  = 8'd1;
						end
					end
				end
			end
			bhm_pkg::CMD_VACUUM: begin
				if (pct != '0 && level_q == bhm_pkg::LVL_CRIT) begin
					r.vacuum_refused = 1'b1;
				end else begin
					r.applied_pct = pct;
					r.fan_write   = 1'b1;
					r.fan_duty    = bhm_pkg::fan_duty_of(pct);
				end
			end
			default: ;
		endcase

		if (enter) begin
			level_n = enter_lvl;
			flash_n = '0;
			alarm_n = '0;
			phase_n = 1'b0;
			if (enter_lvl == bhm_pkg::LVL_CRIT) begin
				r.cut_loads = 1'b1;
				r.fan_write = 1'b1;
				r.fan_duty  = '0;
				r.led_write = 1'b1;
				r.led_red   = bhm_pkg::LED_CRIT_ENTER_R;
				r.tone_kind = bhm_pkg::TONE_ALARM;
			end else if (enter_lvl == bhm_pkg::LVL_LOW) begin
				r.led_write = 1'b1;
				r.led_red   = bhm_pkg::LED_LOW_R;
				r.led_green = bhm_pkg::LED_LOW_G;
				r.tone_kind = bhm_pkg::TONE_HEADS_UP;
			end
		end

		// indication timers run on ticks against the updated level
		if (tick) begin
			if (level_n == bhm_pkg::LVL_CRIT) begin
				if ((item.now_ms - flash_n) >= bhm_pkg::CRIT_FLASH_MS) begin
					flash_n     = item.now_ms;
					phase_n     = ~phase_n;
					r.led_write = 1'b1;
					r.led_red   = phase_n ? bhm_pkg::LED_CRIT_FLASH_R : 8'd0;
					r.led_green = '0;
					r.led_blue  = '0;
				end
				if ((item.now_ms - alarm_n) >= bhm_pkg::CRIT_ALARM_MS) begin
					alarm_n     = item.now_ms;
					r.tone_kind = bhm_pkg::TONE_ALARM;
				end
			end else if (level_n == bhm_pkg::LVL_LOW) begin
				if ((item.now_ms - flash_n) >= bhm_pkg::LOW_FLASH_MS) begin
					flash_n     = item.now_ms;
					r.led_write = 1'b1;
					r.led_red   = bhm_pkg::LED_LOW_R;
					r.led_green = bhm_pkg::LED_LOW_G;
					r.led_blue  = '0;
				end
			end
		end

		r.pack_level = level_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= bhm_pkg::LVL_OK;
			cand_q  <= bhm_pkg::LVL_OK;
			cnt_q   <= '0;
			poll_q  <= '0;
			flash_q <= '0;
			alarm_q <= '0;
			phase_q <= 1'b0;
		end else if (go) begin
			level_q <= level_n;
			cand_q  <= cand_n;
			cnt_q   <= cnt_n;
			poll_q  <= poll_n;
			flash_q <= flash_n;
			alarm_q <= alarm_n;
			phase_q <= phase_n;
		end
	end

	assign res = r;

endmodule

// ===== src/battery_hysteresis_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_hysteresis_monitor - debounced pack voltage level monitor
// Each item passes the input stage register s1, then the result register out_q.
// Throughput: one item per cycle while result.ready is not held low; the state
// update is combinational logic between the input stage register and the result register.
// Reset (arst_n low, async): level OK, debounce and timers cleared,
// registers back to their defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
module battery_hysteresis_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bhm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bhm_pkg::CFG_DATA_W-1:0] cfg_data,
	bhm_in_if.sink                         item,
	bhm_out_if.source                      result
);

	// Pipeline:
	//   s1    - input stage register, loaded on each input transfer
	//   out_q - result register; an item moves s1 -> out when out is
	//           empty or its result is being transferred this cycle.
	// The monitor state lives in bhm_core and advances exactly when an
	// item leaves s1, so items update the state in arrival order.

	bhm_pkg::cfg_t    cfg;
	bhm_pkg::item_t   item_s1;
	bhm_pkg::result_t res_c, res_q;
	logic             v_s1_q, out_valid_q, adv, go;

	bhm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// output stage can take a new result when empty or draining
	assign adv        = !out_valid_q || result.ready;
	assign go         = v_s1_q && adv;
	assign item.ready = !v_s1_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (item.ready) begin
			v_s1_q <= item.valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

	bhm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res_c;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	// a load cut always comes with CRITICAL and a zero fan write
	a_cut_is_crit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.cut_loads |->
			result.data.pack_level == bhm_pkg::LVL_CRIT &&
			result.data.fan_write && result.data.fan_duty == '0)
		else $error("load cut without CRITICAL entry");

	// a refused request writes nothing and applies nothing
	a_refused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.vacuum_refused |->
			!result.data.fan_write && result.data.applied_pct == '0 &&
			result.data.pack_level == bhm_pkg::LVL_CRIT)
		else $error("refused vacuum request still drove the fan");

	// full duty request maps to the full compare value
	a_full_duty: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.applied_pct == bhm_pkg::PCT_MAX |->
			result.data.fan_duty == bhm_pkg::DUTY_MAX)
		else $error("fan duty scaling wrong at 100 percent");

	// a stalled s1 item is neither lost nor overwritten
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q && !adv |=> v_s1_q && $stable(item_s1))
		else $error("input stage lost an item under stall");

endmodule
